// ----- rtl/dtd_pkg.sv -----
package dtd_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 4096;
  localparam int unsigned INDEX_BITS_DEF  = 32;
  localparam logic [7:0]  TRIANGLE_VERTS  = 8'd3;

  typedef struct packed {
    logic        start_mesh;
    logic [7:0]  vertex_count;
    logic [31:0] vertex_a;
    logic [31:0] vertex_b;
    logic [31:0] vertex_c;
  } in_word_t;

  typedef struct packed {
    logic [31:0] facet_number;
    logic        is_duplicate;
    logic        skipped;
    logic        table_full;
    logic [31:0] duplicate_total;
  } out_word_t;

endpackage

// ----- rtl/dtd_ram.sv -----
module dtd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/dtd_front.sv -----
module dtd_front #(
  parameter int unsigned TABLE_SLOTS = dtd_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned INDEX_BITS  = dtd_pkg::INDEX_BITS_DEF,
  localparam int unsigned SB = $clog2(TABLE_SLOTS),
  localparam int unsigned EW = 2 + 3 * INDEX_BITS + SB
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dtd_pkg::in_word_t in_word_i,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  output logic [EW-1:0]    q_data_o
);

  logic [INDEX_BITS-1:0] a0, b0, c0, a1, b1, b2, c1, a2;
  logic [31:0]           fold;
  logic [SB-1:0]         hraw, hash;
  logic [SB:0]           hext;
  logic                  skip;
  logic [EW-1:0]         entry;
  logic [EW-1:0]         fifo_q [2];
  logic                  wptr_q, rptr_q;
  logic [1:0]            cnt_q;
  logic                  push;

  // three compare-swaps sort the key ascending
  always_comb begin
    a0 = in_word_i.vertex_a[INDEX_BITS-1:0];
    b0 = in_word_i.vertex_b[INDEX_BITS-1:0];
    c0 = in_word_i.vertex_c[INDEX_BITS-1:0];
    a1 = (a0 > b0) ? b0 : a0;
    b1 = (a0 > b0) ? a0 : b0;
    b2 = (b1 > c0) ? c0 : b1;
    c1 = (b1 > c0) ? b1 : c0;
    a2 = (a1 > b2) ? b2 : a1;
  end

  logic [INDEX_BITS-1:0] bs;
  assign bs = (a1 > b2) ? a1 : b2;

  // probe start: folded xor of the key, reduced below the slot count
  always_comb begin
    fold = 32'(a2 ^ bs ^ c1);
    hraw = SB'(fold ^ (fold >> 16));
    hext = {1'b0, hraw};
    if (hext >= (SB+1)'(TABLE_SLOTS)) begin
      hash = SB'(hext - (SB+1)'(TABLE_SLOTS));
    end else begin
      hash = hraw;
    end
  end

  assign skip  = in_word_i.vertex_count != dtd_pkg::TRIANGLE_VERTS;
  assign entry = {in_word_i.start_mesh, skip, c1, bs, a2, hash};

  assign in_stall_o = cnt_q == 2'd2;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_data_o   = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (q_pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

// ----- rtl/dtd_back.sv -----
module dtd_back #(
  parameter int unsigned TABLE_SLOTS = dtd_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned INDEX_BITS  = dtd_pkg::INDEX_BITS_DEF,
  localparam int unsigned SB = $clog2(TABLE_SLOTS),
  localparam int unsigned EW = 2 + 3 * INDEX_BITS + SB,
  localparam int unsigned RW = 1 + 3 * INDEX_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  logic [EW-1:0]     q_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dtd_pkg::out_word_t out_word_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CHECK = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  localparam logic [SB-1:0] LAST = SB'(TABLE_SLOTS - 1);

  state_e                state_q, state_d;
  logic [SB-1:0]         clr_q, clr_d, pos_q, pos_d, probes_q, probes_d, nxt;
  logic [INDEX_BITS-1:0] a_q, a_d, b_q, b_d, c_q, c_d;
  logic [31:0]           fcnt_q, fcnt_d, dcnt_q, dcnt_d, num_q, num_d;
  logic                  cleared_q, cleared_d, dup_q, dup_d, skip_q, skip_d;
  logic                  full_q, full_d, out_valid_q, out_valid_d;
  dtd_pkg::out_word_t    out_q, out_d;

  logic                  we;
  logic [SB-1:0]         waddr, raddr;
  logic [RW-1:0]         wdata, rdata;

  logic                  h_start, h_skip;
  logic [INDEX_BITS-1:0] h_a, h_b, h_c;
  logic [SB-1:0]         h_hash;

  assign {h_start, h_skip, h_c, h_b, h_a, h_hash} = q_data_i;

  dtd_ram #(.WIDTH(RW), .DEPTH(TABLE_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign nxt = (pos_q == LAST) ? '0 : pos_q + SB'(1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    probes_d    = probes_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    fcnt_d      = fcnt_q;
    dcnt_d      = dcnt_q;
    num_d       = num_q;
    cleared_d   = cleared_q;
    dup_d       = dup_q;
    skip_d      = skip_q;
    full_d      = full_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = '0;
    raddr       = pos_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + SB'(1);
        if (clr_q == LAST) begin
          clr_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          if (h_start && !cleared_q) begin
            // empty the set before this word is handled
            fcnt_d    = '0;
            dcnt_d    = '0;
            cleared_d = 1'b1;
            state_d   = S_CLEAR;
          end else begin
            q_pop_o   = 1'b1;
            cleared_d = 1'b0;
            num_d     = fcnt_q;
            fcnt_d    = fcnt_q + 32'd1;
            dup_d     = 1'b0;
            full_d    = 1'b0;
            skip_d    = h_skip;
            a_d       = h_a;
            b_d       = h_b;
            c_d       = h_c;
            pos_d     = h_hash;
            raddr     = h_hash;
            probes_d  = '0;
            state_d   = h_skip ? S_DONE : S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (!rdata[RW-1]) begin
          we      = 1'b1;
          wdata   = {1'b1, c_q, b_q, a_q};
          state_d = S_DONE;
        end else if (rdata[RW-2:0] == {c_q, b_q, a_q}) begin
          dup_d = 1'b1;
          if (dcnt_q != '1) begin
            dcnt_d = dcnt_q + 32'd1;
          end
          state_d = S_DONE;
        end else if (probes_q == LAST) begin
          full_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          pos_d    = nxt;
          raddr    = nxt;
          probes_d = probes_q + SB'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.facet_number    = num_q;
          out_d.is_duplicate    = dup_q;
          out_d.skipped         = skip_q;
          out_d.table_full      = full_q;
          out_d.duplicate_total = dcnt_q;
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    probes_q <= probes_d;
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    num_q    <= num_d;
    dup_q    <= dup_d;
    skip_q   <= skip_d;
    full_q   <= full_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      fcnt_q      <= '0;
      dcnt_q      <= '0;
      cleared_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fcnt_q      <= fcnt_d;
      dcnt_q      <= dcnt_d;
      cleared_q   <= cleared_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- rtl/duplicate_triangle_detector.sv -----
// duplicate triangle detector
// input channel: one facet word per handshake (in_valid_i / in_stall_o), with
// start_mesh, vertex count and three vertex indices. output channel: one
// result word per facet (out_valid_o / out_stall_i), in input order.
// the front sorts the three indices and computes the probe start, then parks
// the word in a two-entry queue. the back walks the slot table, one probe per
// cycle through a single-read, single-write table memory.
// a non-triangle's result passes the queue, S_IDLE and S_DONE into the output
// register; a triangle's passes the queue, S_IDLE, S_CHECK for each probe and
// S_DONE. the back pops the next word only once it is back in S_IDLE, while
// the queue keeps taking words. a start_mesh word first runs a clearing pass
// over every slot of the table. after reset the back runs the same clearing
// pass; the queue still takes up to two words meanwhile.
// when the receiver stalls, the result waits in the output register while the
// back finishes the next word and the queue keeps filling; in_stall_o rises
// once the queue holds two words.
module duplicate_triangle_detector #(
  parameter int unsigned TABLE_SLOTS = dtd_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned INDEX_BITS  = dtd_pkg::INDEX_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dtd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dtd_pkg::out_word_t out_word_o
);

  localparam int unsigned SB = $clog2(TABLE_SLOTS);
  localparam int unsigned EW = 2 + 3 * INDEX_BITS + SB;

  logic          q_valid, q_pop;
  logic [EW-1:0] q_data;

  dtd_front #(.TABLE_SLOTS(TABLE_SLOTS), .INDEX_BITS(INDEX_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_data_o   (q_data)
  );

  dtd_back #(.TABLE_SLOTS(TABLE_SLOTS), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
